// ===== design/sibp_pkg.sv =====
// ----------------------------------------------------------------------------
// sibp_pkg
// shared types and constants for the segment index box parser
// ----------------------------------------------------------------------------
package sibp_pkg;

  // parse phases of one box
  typedef enum logic [2:0] {
    PH_HEAD  = 3'd0,
    PH_TIMES = 3'd1,
    PH_COUNT = 3'd2,
    PH_REFS  = 3'd3,
    PH_TAIL  = 3'd4
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_REFERENCE = 2'd1,
    KIND_DONE      = 2'd2,
    KIND_LEN_ERROR = 2'd3
  } kind_t;

  // byte positions that close a field
  localparam logic [3:0] POS_WORD0 = 4'd3;
  localparam logic [3:0] POS_WORD1 = 4'd7;
  localparam logic [3:0] POS_WORD2 = 4'd11;
  localparam logic [3:0] POS_WORD3 = 4'd15;

  // depth of the result queue
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  box_version;
    logic [23:0] box_flags;
    logic [15:0] entry_count;
    logic [31:0] id_or_size;
    logic [31:0] scale_or_duration;
    logic [63:0] earliest_time;
    logic [63:0] offset_or_delta;
    logic        reference_kind;
    logic        starts_with_access_point;
    logic [2:0]  access_point_type;
    logic        last;
  } res_t;

endpackage

// ===== design/sibp_in_if.sv =====
// ----------------------------------------------------------------------------
// sibp_in_if
// byte channel into the segment index box parser
// ----------------------------------------------------------------------------
interface sibp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       end_of_box;

  modport source (output valid, output payload_byte, output end_of_box, input ready);
  modport sink   (input valid, input payload_byte, input end_of_box, output ready);
endinterface

// ===== design/sibp_out_if.sv =====
// ----------------------------------------------------------------------------
// sibp_out_if
// result channel out of the segment index box parser
// ----------------------------------------------------------------------------
interface sibp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  box_version;
  logic [23:0] box_flags;
  logic [15:0] entry_count;
  logic [31:0] id_or_size;
  logic [31:0] scale_or_duration;
  logic [63:0] earliest_time;
  logic [63:0] offset_or_delta;
  logic        reference_kind;
  logic        starts_with_access_point;
  logic [2:0]  access_point_type;
  logic        last;

  modport source (
    output valid, input ready,
    output kind, output box_version, output box_flags, output entry_count,
    output id_or_size, output scale_or_duration, output earliest_time,
    output offset_or_delta, output reference_kind, output starts_with_access_point,
    output access_point_type, output last
  );
  modport sink (
    input valid, output ready,
    input kind, input box_version, input box_flags, input entry_count,
    input id_or_size, input scale_or_duration, input earliest_time,
    input offset_or_delta, input reference_kind, input starts_with_access_point,
    input access_point_type, input last
  );
endinterface

// ===== design/segment_index_box_parser.sv =====
// ----------------------------------------------------------------------------
// segment_index_box_parser
// parses a segment index box payload byte by byte into header, reference,
// done and length error results
// ----------------------------------------------------------------------------
// results: those of a byte are registered into the result queue, whose head entry drives the output
// throughput: one byte per cycle; a byte causes at most two results, queued
//   in a four-entry result queue, and bytes are taken while it has two free
// reset: synchronous active-low rst_n clears parse state and empties the queue
// ----------------------------------------------------------------------------
module segment_index_box_parser
  import sibp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  sibp_in_if.sink   in_if,
  sibp_out_if.source out_if
);

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [23:0] flags_r, flags_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] scale_r, scale_nxt;
  logic [63:0] time_r, time_nxt;
  logic [63:0] offset_r, offset_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [63:0] entry_r, entry_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic        err_wait_r, err_wait_nxt;

  // result queue, head entry drives the output
  res_t              q_r [QDEPTH];
  res_t              q_nxt [QDEPTH];
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  logic accept, pop;
  logic [63:0] ws;
  logic [31:0] w1, w3;

  // results of this byte: a field result and an end-of-box result
  res_t first_res, end_res, slot0, slot1;
  logic first_v, end_v;
  logic push0, push1;
  logic [QCNT_W-1:0] base;

  // take a byte only while two queue entries are free
  assign in_if.ready = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign accept      = in_if.valid && in_if.ready;
  assign pop         = out_if.valid && out_if.ready;

  assign ws = {shift_r[55:0], in_if.payload_byte};
  assign w1 = entry_r[63:32];
  assign w3 = ws[31:0];

  // parser next state and result generation
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    version_nxt  = version_r;
    flags_nxt    = flags_r;
    id_nxt       = id_r;
    scale_nxt    = scale_r;
    time_nxt     = time_r;
    offset_nxt   = offset_r;
    shift_nxt    = shift_r;
    entry_nxt    = entry_r;
    left_nxt     = left_r;
    sum_nxt      = sum_r;
    err_wait_nxt = err_wait_r;
    first_res    = '0;
    end_res      = '0;
    first_v      = 1'b0;
    end_v        = 1'b0;

    if (accept) begin
      if (err_wait_r) begin
        // dropping leftover bytes until the box ends
        if (in_if.end_of_box) begin
          err_wait_nxt = 1'b0;
          phase_nxt    = PH_HEAD;
          pos_nxt      = '0;
          shift_nxt    = '0;
          entry_nxt    = '0;
          left_nxt     = '0;
          sum_nxt      = '0;
        end
      end else if (phase_r == PH_TAIL) begin
        // byte past the last reference
        first_v        = 1'b1;
        first_res.kind = KIND_LEN_ERROR;
        if (in_if.end_of_box) begin
          phase_nxt = PH_HEAD;
          pos_nxt   = '0;
          shift_nxt = '0;
          entry_nxt = '0;
          left_nxt  = '0;
          sum_nxt   = '0;
        end else begin
          err_wait_nxt = 1'b1;
        end
      end else begin
        shift_nxt = ws;
        pos_nxt   = pos_r + 4'd1;
        case (phase_r)
          PH_HEAD: begin
            if (pos_r == POS_WORD0) begin
              version_nxt = ws[31:24];
              flags_nxt   = ws[23:0];
            end
            if (pos_r == POS_WORD1) id_nxt = ws[31:0];
            if (pos_r == POS_WORD2) begin
              scale_nxt = ws[31:0];
              phase_nxt = PH_TIMES;
              pos_nxt   = '0;
            end
          end
          PH_TIMES: begin
            if (version_r == 8'd0) begin
              if (pos_r == POS_WORD0) time_nxt = {32'd0, ws[31:0]};
              if (pos_r == POS_WORD1) begin
                offset_nxt = {32'd0, ws[31:0]};
                phase_nxt  = PH_COUNT;
                pos_nxt    = '0;
              end
            end else begin
              if (pos_r == POS_WORD1) time_nxt = ws;
              if (pos_r == POS_WORD3) begin
                offset_nxt = ws;
                phase_nxt  = PH_COUNT;
                pos_nxt    = '0;
              end
            end
          end
          PH_COUNT: begin
            // reserved bytes then the reference count
            if (pos_r == POS_WORD0) begin
              left_nxt                  = ws[15:0];
              first_v                   = 1'b1;
              first_res.kind            = KIND_HEADER;
              first_res.box_version     = version_r;
              first_res.box_flags       = flags_r;
              first_res.entry_count     = ws[15:0];
              first_res.id_or_size      = id_r;
              first_res.scale_or_duration = scale_r;
              first_res.earliest_time   = time_r;
              first_res.offset_or_delta = offset_r;
              phase_nxt = (ws[15:0] != 16'd0) ? PH_REFS : PH_TAIL;
              pos_nxt   = '0;
            end
          end
          PH_REFS: begin
            if (pos_r == POS_WORD1) entry_nxt = ws;
            if (pos_r == POS_WORD2) begin
              first_v                            = 1'b1;
              first_res.kind                     = KIND_REFERENCE;
              first_res.id_or_size               = {1'b0, w1[30:0]};
              first_res.scale_or_duration        = entry_r[31:0];
              first_res.offset_or_delta          = {36'd0, w3[27:0]};
              first_res.reference_kind           = w1[31];
              first_res.starts_with_access_point = w3[31];
              first_res.access_point_type        = w3[30:28];
              sum_nxt   = sum_r + entry_r[31:0];
              left_nxt  = left_r - 16'd1;
              phase_nxt = (left_r != 16'd1) ? PH_REFS : PH_TAIL;
              pos_nxt   = '0;
            end
          end
          default: begin
            phase_nxt = PH_HEAD;
          end
        endcase

        // end of box: done when all references are in, else short box
        if (in_if.end_of_box) begin
          end_v = 1'b1;
          if (phase_nxt == PH_TAIL) begin
            end_res.kind              = KIND_DONE;
            end_res.scale_or_duration = sum_nxt;
          end else begin
            end_res.kind = KIND_LEN_ERROR;
          end
          phase_nxt = PH_HEAD;
          pos_nxt   = '0;
          shift_nxt = '0;
          entry_nxt = '0;
          left_nxt  = '0;
          sum_nxt   = '0;
        end
      end
    end
  end

  // pack the results of this byte into queue slots and mark the last one
  always_comb begin
    slot1 = end_res;
    slot1.last = 1'b1;
    if (first_v) begin
      slot0 = first_res;
      slot0.last = !end_v;
    end else begin
      slot0 = end_res;
      slot0.last = 1'b1;
    end
    push0 = first_v || end_v;
    push1 = first_v && end_v;
  end

  // queue: shift down on pop, append new results behind the survivors
  always_comb begin
    base = cnt_r - QCNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) q_nxt[i] = q_r[(i + 1) % QDEPTH];
      else                         q_nxt[i] = q_r[i];
      if (push0 && (base == QCNT_W'(i)))          q_nxt[i] = slot0;
      if (push1 && ((base + 1'b1) == QCNT_W'(i))) q_nxt[i] = slot1;
    end
    cnt_nxt = base + QCNT_W'(push0) + QCNT_W'(push1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEAD;
      pos_r      <= '0;
      version_r  <= '0;
      flags_r    <= '0;
      id_r       <= '0;
      scale_r    <= '0;
      time_r     <= '0;
      offset_r   <= '0;
      shift_r    <= '0;
      entry_r    <= '0;
      left_r     <= '0;
      sum_r      <= '0;
      err_wait_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      version_r  <= version_nxt;
      flags_r    <= flags_nxt;
      id_r       <= id_nxt;
      scale_r    <= scale_nxt;
      time_r     <= time_nxt;
      offset_r   <= offset_nxt;
      shift_r    <= shift_nxt;
      entry_r    <= entry_nxt;
      left_r     <= left_nxt;
      sum_r      <= sum_nxt;
      err_wait_r <= err_wait_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // queue payload needs no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) q_r[i] <= q_nxt[i];
  end

  // head of the queue is the output register
  assign out_if.valid                    = (cnt_r != '0);
  assign out_if.kind                     = q_r[0].kind;
  assign out_if.box_version              = q_r[0].box_version;
  assign out_if.box_flags                = q_r[0].box_flags;
  assign out_if.entry_count              = q_r[0].entry_count;
  assign out_if.id_or_size               = q_r[0].id_or_size;
  assign out_if.scale_or_duration        = q_r[0].scale_or_duration;
  assign out_if.earliest_time            = q_r[0].earliest_time;
  assign out_if.offset_or_delta          = q_r[0].offset_or_delta;
  assign out_if.reference_kind           = q_r[0].reference_kind;
  assign out_if.starts_with_access_point = q_r[0].starts_with_access_point;
  assign out_if.access_point_type        = q_r[0].access_point_type;
  assign out_if.last                     = q_r[0].last;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for segment_index_box_parser: bytes of segment index
// box payloads go in over a valid/ready channel, a local box parser predicts
// header, reference, done and length error results, and each result taken
// from the output channel is compared field by field with the oldest one
// ----------------------------------------------------------------------------
module tb;
  import sibp_pkg::*;

  localparam int ITEMS_PER_PHASE = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PRINT_CAP       = 100;

  // one byte of stimulus; err_typed marks a row whose length error is typed in
  typedef struct {
    logic [7:0] data;
    logic       eob;
    bit         err_typed;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sibp_in_if  in_ch ();
  sibp_out_if out_ch ();

  segment_index_box_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // directed rows: first a box cut short right after reset, then a version 0
  // box at the extremes with no references and no end mark, then a leftover
  // byte, one ignored byte and the end-marked byte that re-arms the parser
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [28] = '{
    '{8'h00, 1'b1, 1'b1},                          // end of box on the first byte
    '{8'h00, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},    // version 0, flags all ones
    '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},    // reference id all ones
    '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},    // timescale 1
    '{8'h00, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},    // earliest time, 32 bits
    '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},    // first offset, top bit only
    '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},    // reserved
    '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},    // zero references, header here
    '{8'h5A, 1'b0, 1'b1},                          // leftover byte, error
    '{8'hA5, 1'b0, 1'b0},                          // skipped
    '{8'h00, 1'b1, 1'b0}                           // skipped, re-arms
  };

  // --------------------------------------------------------------------------
  // box parser model state
  // --------------------------------------------------------------------------
  phase_t      box_phase;
  logic [3:0]  byte_pos;
  logic [7:0]  box_ver;
  logic [23:0] box_flg;
  logic [31:0] ref_id;
  logic [31:0] time_scale;
  logic [63:0] first_time;
  logic [63:0] box_offset;
  logic [63:0] byte_shift;
  logic [63:0] ref_head;
  logic [15:0] refs_left;
  logic [31:0] dur_total;
  bit          skip_to_eob;

  res_t awaited_results [$];

  int error_count    = 0;
  int cycle_count    = 0;
  int phase_items    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  function automatic void restart_box();
    box_phase  = PH_HEAD;
    byte_pos   = '0;
    byte_shift = '0;
    ref_head   = '0;
    refs_left  = '0;
    dur_total  = '0;
  endfunction

  function automatic void reset_box_parser();
    restart_box();
    box_ver      = '0;
    box_flg      = '0;
    ref_id       = '0;
    time_scale   = '0;
    first_time   = '0;
    box_offset   = '0;
    skip_to_eob  = 1'b0;
  endfunction

  // results that one accepted byte causes, in order, last flag on the final one
  function automatic void parse_payload_byte(input logic [7:0] data, input logic eob,
                                             output res_t made [$]);
    res_t        r;
    logic [63:0] tmask;
    logic [3:0]  time_end;
    logic [3:0]  offset_end;
    logic [31:0] w1;
    logic [31:0] dur;
    logic [31:0] w3;
    made = {};
    // after leftover bytes everything up to the end mark is dropped
    if (skip_to_eob) begin
      if (eob) begin
        skip_to_eob = 1'b0;
        restart_box();
      end
      return;
    end
    // a byte past the last reference is a length error
    if (box_phase == PH_TAIL) begin
      r = '0;
      r.kind = KIND_LEN_ERROR;
      r.last = 1'b1;
      made.insert(made.size(), r);
      if (eob) restart_box();
      else skip_to_eob = 1'b1;
      return;
    end
    byte_shift = {byte_shift[55:0], data};
    case (box_phase)
      PH_HEAD: begin
        if (byte_pos == POS_WORD0) begin
          box_ver = byte_shift[31:24];
          box_flg = byte_shift[23:0];
        end else if (byte_pos == POS_WORD1) begin
          ref_id = byte_shift[31:0];
        end
        if (byte_pos == POS_WORD2) begin
          time_scale = byte_shift[31:0];
          box_phase  = PH_TIMES;
          byte_pos   = '0;
        end else begin
          byte_pos++;
        end
      end
      PH_TIMES: begin
        // version 0 has 32-bit times, any other version 64-bit
        if (box_ver == 8'd0) begin
          tmask      = 64'h0000_0000_FFFF_FFFF;
          time_end   = POS_WORD0;
          offset_end = POS_WORD1;
        end else begin
          tmask      = {64{1'b1}};
          time_end   = POS_WORD1;
          offset_end = POS_WORD3;
        end
        if (byte_pos == time_end) first_time = byte_shift & tmask;
        if (byte_pos == offset_end) begin
          box_offset   = byte_shift & tmask;
          box_phase    = PH_COUNT;
          byte_pos     = '0;
        end else begin
          byte_pos++;
        end
      end
      PH_COUNT: begin
        // reserved 16 bits, then the reference count closes the header
        if (byte_pos == POS_WORD0) begin
          refs_left           = byte_shift[15:0];
          r                   = '0;
          r.kind              = KIND_HEADER;
          r.box_version       = box_ver;
          r.box_flags         = box_flg;
          r.entry_count       = refs_left;
          r.id_or_size        = ref_id;
          r.scale_or_duration = time_scale;
          r.earliest_time     = first_time;
          r.offset_or_delta   = box_offset;
          made.insert(made.size(), r);
          if (refs_left != 16'd0) box_phase = PH_REFS;
          else box_phase = PH_TAIL;
          byte_pos = '0;
        end else begin
          byte_pos++;
        end
      end
      PH_REFS: begin
        if (byte_pos == POS_WORD1) ref_head = byte_shift;
        if (byte_pos == POS_WORD2) begin
          w1  = ref_head[63:32];
          dur = ref_head[31:0];
          w3  = byte_shift[31:0];
          r   = '0;
          r.kind                     = KIND_REFERENCE;
          r.id_or_size               = {1'b0, w1[30:0]};
          r.scale_or_duration        = dur;
          r.offset_or_delta          = {36'd0, w3[27:0]};
          r.reference_kind           = w1[31];
          r.starts_with_access_point = w3[31];
          r.access_point_type        = w3[30:28];
          made.insert(made.size(), r);
          dur_total = dur_total + dur;
          refs_left--;
          if (refs_left != 16'd0) box_phase = PH_REFS;
          else box_phase = PH_TAIL;
          byte_pos = '0;
        end else begin
          byte_pos++;
        end
      end
      default: ;
    endcase
    // end mark: done if every reference arrived, else the box was short
    if (eob) begin
      r = '0;
      if (box_phase == PH_TAIL) begin
        r.kind              = KIND_DONE;
        r.scale_or_duration = dur_total;
      end else begin
        r.kind = KIND_LEN_ERROR;
      end
      made.insert(made.size(), r);
      restart_box();
    end
    if (made.size() > 0) made[made.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // mismatch reporting and result checking
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // every result taken at an edge is held against the oldest awaited one
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("result of kind %0d with none awaited", out_ch.kind));
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", out_ch.kind, want.kind);
        check_field("box_version", out_ch.box_version, want.box_version);
        check_field("box_flags", out_ch.box_flags, want.box_flags);
        check_field("entry_count", out_ch.entry_count, want.entry_count);
        check_field("id_or_size", out_ch.id_or_size, want.id_or_size);
        check_field("scale_or_duration", out_ch.scale_or_duration,
                    want.scale_or_duration);
        check_field("earliest_time", out_ch.earliest_time, want.earliest_time);
        check_field("offset_or_delta", out_ch.offset_or_delta, want.offset_or_delta);
        check_field("reference_kind", out_ch.reference_kind, want.reference_kind);
        check_field("starts_with_access_point", out_ch.starts_with_access_point,
                    want.starts_with_access_point);
        check_field("access_point_type", out_ch.access_point_type,
                    want.access_point_type);
        check_field("last", out_ch.last, want.last);
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted down here
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("segment_index_box_parser verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------

  // offers one byte, waits for the handshake, then records what it causes;
  // valid stays high across back-to-back items and is only lowered for a gap
  task automatic send_byte(input logic [7:0] data, input logic eob, input bit err_typed);
    res_t made [$];
    res_t typed_err;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= data;
    in_ch.end_of_box   <= eob;
    do @(posedge clk); while (!in_ch.ready);
    parse_payload_byte(data, eob, made);
    if (err_typed) begin
      typed_err      = '0;
      typed_err.kind = KIND_LEN_ERROR;
      typed_err.last = 1'b1;
      awaited_results.insert(awaited_results.size(), typed_err);
    end else begin
      foreach (made[i]) awaited_results.insert(awaited_results.size(), made[i]);
    end
    phase_items++;
  endtask

  // sender pauses until every awaited result has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // 32-bit field value with the extremes weighted in
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // big-endian append of the low nbytes of value
  function automatic void put_bytes(ref logic [7:0] q [$], input logic [63:0] value,
                                    input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) q.insert(q.size(), value[8*i +: 8]);
  endfunction

  // one random box: mostly well formed, the rest cut short, padded with
  // leftover bytes, or plain noise
  task automatic send_random_box();
    logic [7:0]  bytes [$];
    stim_row_t   plan [$];
    logic [7:0]  ver;
    logic [15:0] count;
    int          sel;
    int          n_refs;
    int          hdr_len;
    int          cut;
    int          n_extra;
    sel = $urandom_range(99);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: ver = 8'd0;
      5, 6, 7:       ver = 8'd1;
      default:       ver = 8'($urandom_range(255, 2));
    endcase
    if (sel < 70)
      count = 16'(($urandom_range(9) == 0) ? $urandom_range(8, 4) : $urandom_range(3, 0));
    else if (sel < 80)
      count = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(3, 1));
    else count = 16'($urandom_range(3, 0));
    n_refs = (count == 16'hFFFF) ? 2 : int'(count);

    // version byte followed by 24 flag bits
    put_bytes(bytes, 64'({ver, 24'(rand_word())}), 4);
    put_bytes(bytes, 64'(rand_word()), 4);
    put_bytes(bytes, 64'(rand_word()), 4);
    put_bytes(bytes, {rand_word(), rand_word()}, (ver == 8'd0) ? 4 : 8);
    put_bytes(bytes, {rand_word(), rand_word()}, (ver == 8'd0) ? 4 : 8);
    put_bytes(bytes, 64'(rand_word()), 2);
    put_bytes(bytes, 64'(count), 2);
    hdr_len = bytes.size();
    for (int k = 0; k < n_refs; k++) begin
      put_bytes(bytes, 64'(rand_word()), 4);
      put_bytes(bytes, 64'(rand_word()), 4);
      put_bytes(bytes, 64'(rand_word()), 4);
    end

    if (sel < 70) begin
      // complete box, end mark on its final byte
      foreach (bytes[i])
        plan.insert(plan.size(), '{bytes[i], i == bytes.size() - 1, 1'b0});
    end else if (sel < 80) begin
      // short box: cut where the header or a reference also completes, or anywhere
      case ($urandom_range(2))
        0:       cut = hdr_len;
        1:       cut = (n_refs >= 2) ? hdr_len + 12 * $urandom_range(n_refs - 1, 1)
                                     : $urandom_range(bytes.size() - 1, 1);
        default: cut = $urandom_range(bytes.size() - 1, 1);
      endcase
      for (int i = 0; i < cut; i++)
        plan.insert(plan.size(), '{bytes[i], i == cut - 1, 1'b0});
    end else if (sel < 90) begin
      // leftover bytes after the last reference
      foreach (bytes[i]) plan.insert(plan.size(), '{bytes[i], 1'b0, 1'b0});
      n_extra = $urandom_range(4, 1);
      for (int i = 0; i < n_extra; i++)
        plan.insert(plan.size(), '{8'($urandom), i == n_extra - 1, 1'b0});
    end else begin
      // noise, stray end marks inside, always closed by one
      n_extra = $urandom_range(6, 1);
      for (int i = 0; i < n_extra; i++)
        plan.insert(plan.size(),
                    '{8'($urandom), (i == n_extra - 1) || ($urandom_range(7) == 0), 1'b0});
    end

    foreach (plan[i]) send_byte(plan[i].data, plan[i].eob, plan[i].err_typed);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = 8'h00;
    in_ch.end_of_box   = 1'b0;
    out_ch.ready       = 1'b0;
    reset_box_parser();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, no idling
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].eob, directed_rows[i].err_typed);
    drain_results();

    // random boxes in four idling phases, each closed by a full drain
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // long receiver hold-off so the result queue fills and input stalls
          hold_request   = LONG_HOLD;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) send_random_box();
      drain_results();
    end

    // any stray result in these cycles shows up as unexpected
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("segment_index_box_parser verification clean");
    else $display("segment_index_box_parser verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/sibp_pkg.sv
design/sibp_in_if.sv
design/sibp_out_if.sv
design/segment_index_box_parser.sv
tb/sv/tb.sv
